// ===== rtl/aff2i_pkg.sv =====
// Package with shared constants and the control type for the affine 2D inverse block.
`default_nettype none

package aff2i_pkg;

    // Default word and fraction widths of the Q format.
    localparam int unsigned DEF_WORD_BITS = 32;
    localparam int unsigned DEF_FRAC_BITS = 16;

    // Six quotients are formed per transform: four linear terms, two translation terms.
    localparam int unsigned LANES = 6;

    // Control that travels beside each quotient lane through the divider.
    typedef struct packed {
        logic             valid;
        logic [LANES-1:0] neg;   // Quotient sign for each lane.
        logic [LANES-1:0] ovf;   // Quotient is out of range or the determinant is zero.
    } aff2i_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/aff2i_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage for all six lanes.
`default_nettype none

module aff2i_divider
    import aff2i_pkg::*;
#(
    parameter int unsigned WORD_BITS = DEF_WORD_BITS,
    parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire aff2i_ctl_t                     in_ctl,
    input  wire logic [LANES*(3*WORD_BITS+1)-1:0] in_num,  // Lane 0 in the lowest bits.
    input  wire logic [LANES*(2*WORD_BITS+1)-1:0] in_den,
    output aff2i_ctl_t                          out_ctl,
    output logic [LANES*WORD_BITS-1:0]          out_quo
);

    localparam int unsigned DB = 2 * WORD_BITS + 1;   // Divisor magnitude width.
    localparam int unsigned RW = DB + WORD_BITS;      // Remainder width.
    localparam int unsigned NB = 2 * WORD_BITS + FRAC_BITS + 1;

    // Pipeline registers, one set per stage.
    aff2i_ctl_t               ctl_reg [0:WORD_BITS-1];
    logic [RW-1:0]            rem_reg [0:WORD_BITS-1][0:LANES-1];
    logic [DB-1:0]            den_reg [0:WORD_BITS-1][0:LANES-1];
    logic [WORD_BITS-1:0]     quo_reg [0:WORD_BITS-1][0:LANES-1];

    // Stage inputs.
    aff2i_ctl_t               ctl_in  [0:WORD_BITS-1];
    logic [RW-1:0]            rem_in  [0:WORD_BITS-1][0:LANES-1];
    logic [DB-1:0]            den_in  [0:WORD_BITS-1][0:LANES-1];
    logic [WORD_BITS-1:0]     quo_in  [0:WORD_BITS-1][0:LANES-1];

    genvar s, l;
    generate
        for (s = 0; s < WORD_BITS; s++) begin : g_stage
            localparam int unsigned K = WORD_BITS - 1 - s;

            // Stage 0 takes the pipeline input; later stages take the previous stage.
            if (s == 0) begin : g_first
                assign ctl_in[s] = in_ctl;
            end
            else begin : g_next
                assign ctl_in[s] = ctl_reg[s-1];
            end

            for (l = 0; l < LANES; l++) begin : g_lane
                logic [RW:0]       shifted;
                logic [RW:0]       diff;
                logic [RW-1:0]     rem_next;
                logic [WORD_BITS-1:0] quo_next;

                if (s == 0) begin : g_first
                    assign rem_in[s][l] = in_num[l*RW +: RW];
                    assign den_in[s][l] = in_den[l*DB +: DB];
                    assign quo_in[s][l] = '0;
                end
                else begin : g_next
                    assign rem_in[s][l] = rem_reg[s-1][l];
                    assign den_in[s][l] = den_reg[s-1][l];
                    assign quo_in[s][l] = quo_reg[s-1][l];
                end

                // Trial subtraction of the divisor aligned to this quotient bit.
                always_comb
                begin
                    shifted  = {{(RW+1-DB){1'b0}}, den_in[s][l]} << K;
                    diff     = {1'b0, rem_in[s][l]} - shifted;
                    rem_next = diff[RW] ? rem_in[s][l] : diff[RW-1:0];
                    quo_next = {quo_in[s][l][WORD_BITS-2:0], ~diff[RW]};
                end

                // Payload registers carry no reset.
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[s][l] <= rem_next;
                        den_reg[s][l] <= den_in[s][l];
                        quo_reg[s][l] <= quo_next;
                    end
                end

                assign out_quo[l*WORD_BITS +: WORD_BITS] = quo_reg[WORD_BITS-1][l];
            end

            // Control register for this stage.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    ctl_reg[s] <= '0;
                end
                else if (en)
                begin
                    ctl_reg[s] <= ctl_in[s];
                end
            end
        end
    endgenerate

    assign out_ctl = ctl_reg[WORD_BITS-1];

    // The numerator fits the remainder width only while FRAC_BITS does not exceed WORD_BITS.
    localparam logic NUM_FITS = (NB <= RW);
    if (!NUM_FITS) begin : g_bad_width
        aff2i_ctl_t unused_ctl;
        assign unused_ctl = '0;
    end

endmodule

`default_nettype wire

// ===== rtl/affine_2d_inverse_core.sv =====
// Top level of the 2D affine transform inverse in signed fixed point.
// Pipeline from input transaction to result: one multiply stage, one determinant and
// numerator stage, one range precheck stage, one divider stage per quotient bit,
// and the output register.
// Throughput: one transform per cycle; the whole pipeline holds while the output stalls.
// Reset: rst_n clears all valid bits asynchronously; no result is pending after reset.
`default_nettype none

module affine_2d_inverse_core
    import aff2i_pkg::*;
#(
    parameter int unsigned WORD_BITS = DEF_WORD_BITS,
    parameter int unsigned FRAC_BITS = DEF_FRAC_BITS,
    localparam int unsigned IN_W  = ((LANES * WORD_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_W = ((LANES * WORD_BITS + 1 + 7) / 8) * 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // lin_11, lin_12, lin_21, lin_22, shift_x, shift_y, zero pad
    input  wire logic [IN_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // ok, inv_11, inv_12, inv_21, inv_22, inv_shift_x, inv_shift_y, zero pad
    output logic [OUT_W-1:0]       m_axis_tdata
);

    localparam int unsigned W   = WORD_BITS;
    localparam int unsigned F   = FRAC_BITS;
    localparam int unsigned PW  = 2 * W;          // Product width.
    localparam int unsigned DB  = 2 * W + 1;      // Determinant width.
    localparam int unsigned NB  = 2 * W + F + 1;  // Numerator magnitude width.
    localparam int unsigned SNB = NB + 1;         // Signed numerator width.
    localparam int unsigned RW  = DB + W;         // Divider remainder width.

    logic en;

    // Stage 1: products.
    logic                 v1_reg;
    logic signed [W-1:0]  a_reg, b_reg, c_reg, d_reg;
    logic signed [PW-1:0] p_ad_reg, p_bc_reg, p_tyc_reg, p_txd_reg, p_txb_reg, p_tya_reg;
    logic signed [W-1:0]  a_in, b_in, c_in, d_in, tx_in, ty_in;

    // Stage 2: determinant and numerator magnitudes.
    logic                 v2_reg;
    logic [DB-1:0]        dmag_reg;
    logic                 dneg_reg;
    logic [NB-1:0]        nmag_reg [0:LANES-1];
    logic [LANES-1:0]     nneg_reg;
    logic signed [DB-1:0] det;
    logic signed [DB-1:0] t4, t5;
    logic signed [SNB-1:0] num [0:LANES-1];

    // Stage 3: divider input.
    aff2i_ctl_t           ctl3_reg;
    logic [LANES*RW-1:0]  num3_reg;
    logic [LANES*DB-1:0]  den3_reg;
    aff2i_ctl_t           ctl3_next;

    // Divider output.
    aff2i_ctl_t           div_ctl;
    logic [LANES*W-1:0]   div_quo;

    // Output stage.
    logic                 out_valid_reg;
    logic                 out_ok_reg;
    logic [LANES*W-1:0]   out_inv_reg;
    logic                 ok_next;
    logic [LANES*W-1:0]   inv_next;

    // The pipeline moves whenever the output register is free or being emptied.
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Field unpacking.
    assign a_in  = s_axis_tdata[0*W +: W];
    assign b_in  = s_axis_tdata[1*W +: W];
    assign c_in  = s_axis_tdata[2*W +: W];
    assign d_in  = s_axis_tdata[3*W +: W];
    assign tx_in = s_axis_tdata[4*W +: W];
    assign ty_in = s_axis_tdata[5*W +: W];

    // Stage 1 registers: six signed products and the four linear coefficients.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= a_in;
            b_reg     <= b_in;
            c_reg     <= c_in;
            d_reg     <= d_in;
            p_ad_reg  <= a_in * d_in;
            p_bc_reg  <= b_in * c_in;
            p_tyc_reg <= ty_in * c_in;
            p_txd_reg <= tx_in * d_in;
            p_txb_reg <= tx_in * b_in;
            p_tya_reg <= ty_in * a_in;
        end
    end

    // Determinant and signed numerators.
    always_comb
    begin
        det    = DB'(p_ad_reg) - DB'(p_bc_reg);
        t4     = DB'(p_tyc_reg) - DB'(p_txd_reg);
        t5     = DB'(p_txb_reg) - DB'(p_tya_reg);
        num[0] = SNB'(d_reg) << (2 * F);
        num[1] = -(SNB'(b_reg) << (2 * F));
        num[2] = -(SNB'(c_reg) << (2 * F));
        num[3] = SNB'(a_reg) << (2 * F);
        num[4] = SNB'(t4) << F;
        num[5] = SNB'(t5) << F;
    end

    // Stage 2 registers: magnitudes and signs.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dneg_reg <= det[DB-1];
            dmag_reg <= det[DB-1] ? DB'(-det) : DB'(det);
            for (int i = 0; i < LANES; i++)
            begin
                nneg_reg[i] <= num[i][SNB-1];
                nmag_reg[i] <= num[i][SNB-1] ? NB'(-num[i]) : NB'(num[i]);
            end
        end
    end

    // Precheck: a quotient of 2^W or more is out of range. A zero determinant
    // also lands here, since every magnitude is at least zero.
    always_comb
    begin
        ctl3_next.valid = v2_reg;
        for (int i = 0; i < LANES; i++)
        begin
            ctl3_next.neg[i] = nneg_reg[i] ^ dneg_reg;
            ctl3_next.ovf[i] = {{(RW-NB){1'b0}}, nmag_reg[i]} >= ({dmag_reg, {W{1'b0}}});
        end
    end

    // Stage 3 registers: divider operands.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                num3_reg[i*RW +: RW] <= {{(RW-NB){1'b0}}, nmag_reg[i]};
                den3_reg[i*DB +: DB] <= dmag_reg;
            end
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            v1_reg   <= s_axis_tvalid;
            v2_reg   <= v1_reg;
            ctl3_reg <= ctl3_next;
        end
    end

    aff2i_divider #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_ctl  (ctl3_reg),
        .in_num  (num3_reg),
        .in_den  (den3_reg),
        .out_ctl (div_ctl),
        .out_quo (div_quo)
    );

    // Final range check and sign restore; any failing lane zeroes the whole result.
    always_comb
    begin
        logic [W-1:0] q;
        logic         fits;
        ok_next  = 1'b1;
        inv_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            q    = div_quo[i*W +: W];
            fits = !q[W-1] || (div_ctl.neg[i] && (q[W-2:0] == '0));
            if (div_ctl.ovf[i] || !fits)
            begin
                ok_next = 1'b0;
            end
            inv_next[i*W +: W] = div_ctl.neg[i] ? W'(-q) : q;
        end
        if (!ok_next)
        begin
            inv_next = '0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_ok_reg  <= ok_next;
            out_inv_reg <= inv_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W-LANES*W-1){1'b0}}, out_inv_reg, out_ok_reg};

endmodule

`default_nettype wire

// ===== rtl/aff2i_checker.sv =====
// Port-level checker for the affine 2D inverse block and its bind statement.
`default_nettype none

module aff2i_checker
    import aff2i_pkg::*;
#(
    parameter int unsigned WORD_BITS = DEF_WORD_BITS,
    localparam int unsigned IN_W  = ((LANES * WORD_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_W = ((LANES * WORD_BITS + 1 + 7) / 8) * 8
)
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic [IN_W-1:0]  s_axis_tdata,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata
);

    // A result that is not ok carries all-zero inverse fields.
    a_zero_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[OUT_W-1:1] == '0)
        else $error("inverse fields not zero on a failed result");

    // The input side is ready exactly when the output register can move.
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow the output stage");

    // A stalled result stays presented unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // No result is presented in the cycle that follows a cycle in reset.
    a_no_result_from_reset: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid || $past(rst_n))
        else $error("result appeared straight out of reset");

    logic unused_in;
    assign unused_in = s_axis_tvalid ^ (^s_axis_tdata);

endmodule

bind affine_2d_inverse_core aff2i_checker #(
    .WORD_BITS (WORD_BITS)
) u_aff2i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
